### hw/rtl/chb_pkg.sv
`default_nettype none
package chb_pkg;

    localparam int MaxBuckets = 8;
    localparam int SampleW    = 32;
    localparam int CountW     = 48;
    localparam int SumW       = 64;
    localparam int SelW       = 3;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    // Bound registers after reset: 0.005 .. 1.0 in Q16.16.
    localparam logic signed [SampleW-1:0] BoundReset [MaxBuckets] = '{
        32'sd328, 32'sd655, 32'sd1638, 32'sd3277,
        32'sd6554, 32'sd16384, 32'sd32768, 32'sd65536
    };

    typedef struct packed {
        logic                       mode;
        logic signed [SampleW-1:0]  sample;
        logic [SelW-1:0]            sel;
        logic [MaxBuckets-1:0]      hit;
    } chb_item_t;

endpackage
`default_nettype wire

### hw/rtl/chb_front.sv
`default_nettype none
module chb_front
    import chb_pkg::*;
#(
    parameter int NUM_BUCKETS = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [SelW-1:0]           cfg_index,
    input  wire logic [SampleW-1:0]        cfg_data,
    input  wire logic                      mode,
    input  wire logic signed [SampleW-1:0] sample,
    input  wire logic [SelW-1:0]           bucket_select,
    output chb_item_t                      item
);

    logic signed [SampleW-1:0] bound_reg [MaxBuckets];
    logic [MaxBuckets-1:0]     hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxBuckets; i++)
            begin
                bound_reg[i] <= BoundReset[i];
            end
        end
        else if (cfg_write)
        begin
            bound_reg[cfg_index] <= cfg_data;
        end
    end

    // Bounds at or beyond NUM_BUCKETS are kept but never compared.
    always_comb
    begin
        hit = '0;
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            hit[i] = !mode && (sample <= bound_reg[i]);
        end
    end

    assign item.mode   = mode;
    assign item.sample = sample;
    assign item.sel    = bucket_select;
    assign item.hit    = hit;

endmodule
`default_nettype wire

### hw/rtl/chb_queue.sv
`default_nettype none
module chb_queue
    import chb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire chb_item_t  push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output chb_item_t       head
);

    chb_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/chb_back.sv
`default_nettype none
module chb_back
    import chb_pkg::*;
#(
    parameter int NUM_BUCKETS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_not_empty,
    input  wire chb_item_t              q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [CountW-1:0]           bucket_count,
    output logic [CountW-1:0]           total_count,
    output logic signed [SumW-1:0]      total_sum
);

    logic [CountW-1:0]      cnt_reg [NUM_BUCKETS];
    logic [CountW-1:0]      cnt_next [NUM_BUCKETS];
    logic [CountW-1:0]      total_reg;
    logic [CountW-1:0]      total_next;
    logic signed [SumW-1:0] sum_reg;
    logic signed [SumW-1:0] sum_next;
    logic signed [SumW-1:0] addend;
    logic signed [SumW-1:0] raw_sum;
    logic [CountW-1:0]      sel_count;
    logic                   observe;

    logic                   out_valid_reg;
    logic [CountW-1:0]      bucket_count_reg;
    logic [CountW-1:0]      total_count_reg;
    logic signed [SumW-1:0] total_sum_reg;

    assign q_pop   = q_not_empty && (!out_valid_reg || out_ready);
    assign observe = q_pop && !q_head.mode;

    always_comb
    begin
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            if (observe && q_head.hit[i] && cnt_reg[i] != CountMax)
            begin
                cnt_next[i] = cnt_reg[i] + CountW'(1);
            end
        end
    end

    always_comb
    begin
        total_next = total_reg;
        if (observe && total_reg != CountMax)
        begin
            total_next = total_reg + CountW'(1);
        end
    end

    // Overflow only when both operands share a sign the result lacks.
    always_comb
    begin
        addend   = SumW'(q_head.sample);
        raw_sum  = sum_reg + addend;
        sum_next = sum_reg;
        if (observe)
        begin
            if (sum_reg[SumW-1] == addend[SumW-1] && raw_sum[SumW-1] != sum_reg[SumW-1])
            begin
                sum_next = sum_reg[SumW-1] ? {1'b1, {(SumW-1){1'b0}}}
                                           : {1'b0, {(SumW-1){1'b1}}};
            end
            else
            begin
                sum_next = raw_sum;
            end
        end
    end

    // A selection beyond the last bucket reads as zero.
    always_comb
    begin
        sel_count = '0;
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            if ({1'b0, q_head.sel} == (SelW+1)'(i))
            begin
                sel_count = cnt_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            total_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            total_reg <= total_next;
            sum_reg   <= sum_next;
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bucket_count_reg <= sel_count;
            total_count_reg  <= total_next;
            total_sum_reg    <= sum_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bucket_count = bucket_count_reg;
    assign total_count  = total_count_reg;
    assign total_sum    = total_sum_reg;

endmodule
`default_nettype wire

### hw/rtl/cumulative_bucket_histogram.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_write              cfg_index, cfg_data
// in        in         in_valid / in_ready    mode, sample, bucket_select
// out       out        out_valid / out_ready  bucket_count, total_count, total_sum
//
// One beat per cycle sustained while out_ready is high; each input beat goes through the bound
// compare into a two-entry queue, then through the counter update into the output register.
// Throughput is set by the counter and 64-bit sum update in the back end.
// Reset clears all counters and loads the default bounds; no clearing pass is needed.
// A stalled output holds the back end; the queue keeps accepting until it holds two items.
`default_nettype none
module cumulative_bucket_histogram
    import chb_pkg::*;
#(
    parameter int NUM_BUCKETS = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [SelW-1:0]           cfg_index,
    input  wire logic [SampleW-1:0]        cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      mode,
    input  wire logic signed [SampleW-1:0] sample,
    input  wire logic [SelW-1:0]           bucket_select,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [CountW-1:0]              bucket_count,
    output logic [CountW-1:0]              total_count,
    output logic signed [SumW-1:0]         total_sum
);

    chb_item_t front_item;
    chb_item_t q_head;
    logic      q_full;
    logic      q_not_empty;
    logic      q_pop;
    logic      push;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    chb_front #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .sample        (sample),
        .bucket_select (bucket_select),
        .item          (front_item)
    );

    chb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    chb_back #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bucket_count (bucket_count),
        .total_count  (total_count),
        .total_sum    (total_sum)
    );

endmodule
`default_nettype wire
